@@ rtl/mct_pkg.sv @@
`default_nettype none

package mct_pkg;

	// default geometry
	localparam int MCT_POSITION_BITS = 16;
	localparam int MCT_BUTTON_COUNT  = 3;

	// depth of the job queue between front and back
	localparam int MCT_QUEUE_DEPTH = 2;

	// configuration register indexes
	localparam int CFG_ADDR_W = 3;
	localparam logic [CFG_ADDR_W-1:0] REG_POSITION_MODE = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_AREA_LEFT     = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_AREA_RIGHT    = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_AREA_TOP      = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_AREA_BOTTOM   = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_HOTSPOT_X     = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_HOTSPOT_Y     = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_EVENTS_ENABLE = 3'd7;

	// position modes
	localparam logic [1:0] MODE_RELATIVE = 2'd0;
	localparam logic [1:0] MODE_ABSOLUTE = 2'd1;

	// event kinds
	localparam logic [1:0] KIND_MOVE        = 2'd0;
	localparam logic [1:0] KIND_BUTTON_DOWN = 2'd1;
	localparam logic [1:0] KIND_BUTTON_UP   = 2'd2;

endpackage

`default_nettype wire

@@ rtl/mct_fifo.sv @@
`default_nettype none

module mct_fifo
	import mct_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = MCT_QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] head_data,
	output logic                  full,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == FULL_CNT);
	assign empty     = (count_q == '0);
	assign head_data = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/mct_front.sv @@
`default_nettype none

module mct_front
	import mct_pkg::*;
#(
	parameter int POSITION_BITS = MCT_POSITION_BITS,
	parameter int BUTTON_COUNT  = MCT_BUTTON_COUNT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [CFG_ADDR_W-1:0]           cfg_addr,
	input  wire logic [POSITION_BITS-1:0]        cfg_wdata,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic signed [POSITION_BITS-1:0] axis_x,
	input  wire logic signed [POSITION_BITS-1:0] axis_y,
	input  wire logic [BUTTON_COUNT-1:0]         button_levels,
	output logic                                 push_valid,
	output logic [2*BUTTON_COUNT+2*POSITION_BITS:0] push_data,
	input  wire logic                            queue_full
);

	localparam int P = POSITION_BITS;
	localparam int B = BUTTON_COUNT;
	localparam logic signed [P-1:0] POS_MAX = {1'b0, {(P-1){1'b1}}};
	localparam logic signed [P-1:0] POS_MIN = {1'b1, {(P-1){1'b0}}};

	typedef struct packed {
		logic [B-1:0]          chg;
		logic [B-1:0]          lvl;
		logic                  move;
		logic signed [P-1:0]   ex;
		logic signed [P-1:0]   ey;
	} job_t;

	function automatic logic signed [P-1:0] sat_add(input logic signed [P-1:0] a,
			input logic signed [P-1:0] b);
		logic signed [P:0] s;
		s = {a[P-1], a} + {b[P-1], b};
		if (s[P] != s[P-1]) begin
			sat_add = s[P] ? POS_MIN : POS_MAX;
		end else begin
			sat_add = s[P-1:0];
		end
	endfunction

	// configuration registers
	logic [1:0]          mode_q;
	logic signed [P-1:0] left_q, right_q, top_q, bottom_q;
	logic signed [P-1:0] hot_x_q, hot_y_q;
	logic                ev_en_q;

	// tracker state
	logic signed [P-1:0] cursor_x_q, cursor_y_q;
	logic [B-1:0]        held_q;

	// classified report
	logic                valid_s1;
	logic [B-1:0]        chg_s1, lvl_s1;
	logic                move_s1;
	logic signed [P-1:0] cx_s1, cy_s1;

	logic signed [P-1:0] nx, ny, x1, y1, cx, cy;
	logic                accept, advance;
	job_t                job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_RELATIVE;
			left_q   <= POS_MIN;
			right_q  <= POS_MAX;
			top_q    <= POS_MIN;
			bottom_q <= POS_MAX;
			hot_x_q  <= '0;
			hot_y_q  <= '0;
			ev_en_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_POSITION_MODE: mode_q   <= cfg_wdata[1:0];
				REG_AREA_LEFT:     left_q   <= cfg_wdata;
				REG_AREA_RIGHT:    right_q  <= cfg_wdata;
				REG_AREA_TOP:      top_q    <= cfg_wdata;
				REG_AREA_BOTTOM:   bottom_q <= cfg_wdata;
				REG_HOTSPOT_X:     hot_x_q  <= cfg_wdata;
				REG_HOTSPOT_Y:     hot_y_q  <= cfg_wdata;
				REG_EVENTS_ENABLE: ev_en_q  <= cfg_wdata[0];
				default:           ;
			endcase
		end
	end

	// position update, then clamp left, right, top, bottom in that order
	always_comb begin
		case (mode_q)
			MODE_RELATIVE: begin
				nx = sat_add(cursor_x_q, axis_x);
				ny = sat_add(cursor_y_q, axis_y);
			end
			MODE_ABSOLUTE: begin
				nx = axis_x;
				ny = axis_y;
			end
			default: begin
				nx = cursor_x_q;
				ny = cursor_y_q;
			end
		endcase
		x1 = (nx < left_q) ? left_q : nx;
		cx = (x1 > right_q) ? right_q : x1;
		y1 = (ny < top_q) ? top_q : ny;
		cy = (y1 > bottom_q) ? bottom_q : y1;
	end

	// a report that makes no event never enters the queue
	assign push_valid = valid_s1 && ((|chg_s1) || move_s1);
	assign advance    = !valid_s1 || !push_valid || !queue_full;
	assign in_ready   = advance;
	assign accept     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			held_q     <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (accept) begin
				cursor_x_q <= cx;
				cursor_y_q <= cy;
				if (ev_en_q) begin
					held_q <= button_levels;
				end
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			chg_s1  <= ev_en_q ? (button_levels ^ held_q) : '0;
			lvl_s1  <= button_levels;
			move_s1 <= ev_en_q && ((cx != cursor_x_q) || (cy != cursor_y_q));
			cx_s1   <= cx;
			cy_s1   <= cy;
		end
	end

	// hotspot offset for the move event
	always_comb begin
		job.chg  = chg_s1;
		job.lvl  = lvl_s1;
		job.move = move_s1;
		job.ex   = sat_add(cx_s1, hot_x_q);
		job.ey   = sat_add(cy_s1, hot_y_q);
	end

	assign push_data = job;

endmodule

`default_nettype wire

@@ rtl/mct_back.sv @@
`default_nettype none

module mct_back
	import mct_pkg::*;
#(
	parameter int POSITION_BITS = MCT_POSITION_BITS,
	parameter int BUTTON_COUNT  = MCT_BUTTON_COUNT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [2*BUTTON_COUNT+2*POSITION_BITS:0] head_data,
	input  wire logic                            queue_empty,
	output logic                                 pop,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [1:0]                           event_kind,
	output logic signed [POSITION_BITS-1:0]      event_x,
	output logic signed [POSITION_BITS-1:0]      event_y,
	output logic [((BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1)-1:0] button_index,
	output logic                                 last_event
);

	localparam int P     = POSITION_BITS;
	localparam int B     = BUTTON_COUNT;
	localparam int IDX_W = (B > 1) ? $clog2(B) : 1;

	typedef struct packed {
		logic [B-1:0]          chg;
		logic [B-1:0]          lvl;
		logic                  move;
		logic signed [P-1:0]   ex;
		logic signed [P-1:0]   ey;
	} job_t;

	job_t             cur_q;
	logic             cur_valid_q;
	logic             out_valid_q;
	logic [IDX_W-1:0] idx;
	logic [B-1:0]     sel;
	logic [B-1:0]     rem;
	logic             has_btn, last, out_free, emit, finish, load;

	// highest changed button first
	always_comb begin
		idx = '0;
		sel = '0;
		for (int b = 0; b < B; b++) begin
			if (cur_q.chg[b]) begin
				idx = IDX_W'(b);
				sel = B'(1) << b;
			end
		end
		has_btn = |cur_q.chg;
		rem     = cur_q.chg & ~sel;
		last    = !has_btn || ((rem == '0) && !cur_q.move);
	end

	assign out_free = !out_valid_q || out_ready;
	assign emit     = cur_valid_q && out_free;
	assign finish   = emit && last;
	assign load     = (!cur_valid_q || finish) && !queue_empty;
	assign pop      = load;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cur_valid_q <= 1'b1;
			end else if (finish) begin
				cur_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// current job and output word
	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= head_data;
		end else if (emit) begin
			cur_q.chg <= rem;
		end
		if (emit) begin
			last_event <= last;
			if (has_btn) begin
				event_kind   <= cur_q.lvl[idx] ? KIND_BUTTON_DOWN : KIND_BUTTON_UP;
				event_x      <= '0;
				event_y      <= '0;
				button_index <= idx;
			end else begin
				event_kind   <= KIND_MOVE;
				event_x      <= cur_q.ex;
				event_y      <= cur_q.ey;
				button_index <= '0;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/mouse_cursor_tracker.sv @@
// Channel  Dir  tdata (low bit up)                      tuser       tlast
// s_axis   in   axis_x, axis_y, button_levels           -           -
// m_axis   out  event_x, event_y, button_index          event_kind  last_event
// cfg      in   cfg_we / cfg_addr / cfg_wdata, no read-back
//
// The front registers each report; reports enter every cycle unless a held
// report waits on a full job queue. The back sends one event word per cycle
// unless m_axis stalls, and the back sets the rate; a report with k events (at most
// BUTTON_COUNT + 1) goes via a queue slot and the back's job and output registers.
// Reset is asynchronous: position 0, all buttons released, registers at defaults.
// A stalled m_axis fills the two-entry job queue, then stalls s_axis.
`default_nettype none

module mouse_cursor_tracker
	import mct_pkg::*;
#(
	parameter int POSITION_BITS = MCT_POSITION_BITS,
	parameter int BUTTON_COUNT  = MCT_BUTTON_COUNT
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_ADDR_W-1:0]    cfg_addr,
	input  wire logic [POSITION_BITS-1:0] cfg_wdata,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	// axis_x, axis_y, button_levels, zero pad
	input  wire logic [((2*POSITION_BITS+BUTTON_COUNT+7)/8)*8-1:0] s_tdata,
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	// event_x, event_y, button_index, zero pad
	output logic [((2*POSITION_BITS+((BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1)+7)/8)*8-1:0]
		m_tdata,
	// event_kind
	output logic [1:0]                    m_tuser,
	output logic                          m_tlast
);

	localparam int P          = POSITION_BITS;
	localparam int B          = BUTTON_COUNT;
	localparam int IDX_W      = (B > 1) ? $clog2(B) : 1;
	localparam int OUT_DATA_W = ((2*P + IDX_W + 7) / 8) * 8;
	localparam int JOB_W      = 2*B + 2*P + 1;

	logic             push_valid, pop, q_full, q_empty;
	logic [JOB_W-1:0] push_data, head_data;
	logic signed [P-1:0] event_x, event_y;
	logic [IDX_W-1:0]    button_index;

	mct_front #(
		.POSITION_BITS(P),
		.BUTTON_COUNT (B)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.axis_x       (s_tdata[P-1:0]),
		.axis_y       (s_tdata[2*P-1:P]),
		.button_levels(s_tdata[2*P+B-1:2*P]),
		.push_valid   (push_valid),
		.push_data    (push_data),
		.queue_full   (q_full)
	);

	mct_fifo #(
		.WIDTH(JOB_W),
		.DEPTH(MCT_QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_valid),
		.push_data(push_data),
		.pop      (pop),
		.head_data(head_data),
		.full     (q_full),
		.empty    (q_empty)
	);

	mct_back #(
		.POSITION_BITS(P),
		.BUTTON_COUNT (B)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_data   (head_data),
		.queue_empty (q_empty),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.event_kind  (m_tuser),
		.event_x     (event_x),
		.event_y     (event_y),
		.button_index(button_index),
		.last_event  (m_tlast)
	);

	// pack the output word
	assign m_tdata = OUT_DATA_W'({button_index, event_y, event_x});

endmodule

`default_nettype wire

@@ rtl/mct_checker.sv @@
`default_nettype none

module mct_checker
	import mct_pkg::*;
#(
	parameter int POSITION_BITS = MCT_POSITION_BITS,
	parameter int BUTTON_COUNT  = MCT_BUTTON_COUNT
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [((2*POSITION_BITS+((BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1)+7)/8)*8-1:0]
		m_tdata,
	input wire logic [1:0] m_tuser,
	input wire logic       m_tlast
);

	localparam int P     = POSITION_BITS;
	localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output word changed while stalled");

	// the move event always closes its report
	a_move_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_MOVE) |-> m_tlast)
		else $error("move event not marked last");

	// button events carry no position
	a_btn_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != KIND_MOVE) |-> (m_tdata[2*P-1:0] == '0))
		else $error("button event with nonzero position");

	// move events carry button index zero
	a_move_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_MOVE) |-> (m_tdata[2*P+IDX_W-1:2*P] == '0))
		else $error("move event with nonzero button index");

endmodule

bind mouse_cursor_tracker mct_checker #(
	.POSITION_BITS(POSITION_BITS),
	.BUTTON_COUNT (BUTTON_COUNT)
) u_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);

`default_nettype wire
